>>> design/first_fit_block_allocator_top_defines.svh
// Assertion macros for the first-fit block allocator checker.
// Used by the checker file; needs clk and rst in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Condition in the same cycle implies consequence.
`define FFBA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Condition implies consequence in the next cycle.
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

>>> design/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int POOL_BYTES_DEF = 4096;
  localparam int MAX_BLOCKS_DEF = 64;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [12:0] req_size;
    logic [11:0] free_offset;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] result_offset;
    logic [12:0] used_bytes;
  } rsp_t;

  // Control part of the token that walks the cell chain
  typedef struct packed {
    logic active;  // token present at this cell
    logic func;    // operation of the request
    logic found;   // an earlier cell already served the request
    logic ins;     // carried entry must be inserted, later entries shift up
  } tok_ctrl_t;

endpackage

>>> design/ffba_cell.sv
// One table entry of the allocator chain, plus one stage of the walking token.
// Depends on ffba_pkg.
module ffba_cell import ffba_pkg::*; #(
  parameter int POOL_BYTES = POOL_BYTES_DEF,
  parameter bit FIRST      = 1'b0,
  parameter int OW         = $clog2(POOL_BYTES),
  parameter int SW         = $clog2(POOL_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          full,
  input  logic [12:0]   req_size,
  input  logic [11:0]   free_offset,
  input  tok_ctrl_t     tin,
  input  logic          tin_cval,
  input  logic          tin_calloc,
  input  logic [OW-1:0] tin_coff,
  input  logic [SW-1:0] tin_csize,
  input  logic [OW-1:0] tin_roff,
  input  logic [SW-1:0] tin_rsize,
  output tok_ctrl_t     tout,
  output logic          tout_cval,
  output logic          tout_calloc,
  output logic [OW-1:0] tout_coff,
  output logic [SW-1:0] tout_csize,
  output logic [OW-1:0] tout_roff,
  output logic [SW-1:0] tout_rsize,
  output logic          val
);

  localparam int RW = (SW > 13) ? SW : 13;
  localparam int KW = (OW > 12) ? OW : 12;

  logic          alloc;
  logic [OW-1:0] offset;
  logic [SW-1:0] size;
  logic          hit_alloc;
  logic          hit_free;
  logic [SW-1:0] rest;

  // Match tests of this entry against the passing request
  assign hit_alloc = tin.active && !tin.found && (tin.func == FUNC_ALLOC) && val && !alloc &&
                     (req_size != 13'd0) && (RW'(size) >= RW'(req_size));
  assign hit_free  = tin.active && !tin.found && (tin.func == FUNC_FREE) && val && alloc &&
                     (KW'(offset) == KW'(free_offset));
  assign rest      = size - SW'(req_size);

  // Entry state: take the carried entry during an insert wave, update on a hit
  always_ff @(posedge clk) begin
    if (rst) begin
      val    <= FIRST;
      alloc  <= 1'b0;
      offset <= '0;
      size   <= FIRST ? SW'(POOL_BYTES) : '0;
    end else if (tin.active && tin.ins) begin
      val    <= tin_cval;
      alloc  <= tin_calloc;
      offset <= tin_coff;
      size   <= tin_csize;
    end else if (hit_alloc) begin
      alloc <= 1'b1;
      size  <= SW'(req_size);
    end else if (hit_free) begin
      alloc <= 1'b0;
    end
  end

  // Token stage: advance the request and its result to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tout <= '0;
    end else begin
      tout.active <= tin.active;
      tout.func   <= tin.func;
      tout.found  <= tin.found || hit_alloc || hit_free;
      tout.ins    <= tin.active && (tin.ins || (hit_alloc && (rest != '0) && !full));
    end
  end

  always_ff @(posedge clk) begin
    if (tin.ins) begin
      tout_cval   <= val;
      tout_calloc <= alloc;
      tout_coff   <= offset;
      tout_csize  <= size;
    end else begin
      tout_cval   <= 1'b1;
      tout_calloc <= 1'b0;
      tout_coff   <= OW'(SW'(offset) + SW'(req_size));
      tout_csize  <= rest;
    end
    if (hit_alloc) begin
      tout_roff  <= offset;
      tout_rsize <= SW'(req_size);
    end else if (hit_free) begin
      tout_roff  <= offset;
      tout_rsize <= size;
    end else begin
      tout_roff  <= tin_roff;
      tout_rsize <= tin_rsize;
    end
  end

endmodule

>>> design/first_fit_block_allocator_top.sv
// First-fit block allocator: top level with the cell chain and its controller.
// Depends on ffba_pkg and ffba_cell.
//
// Each table entry lives in its own cell. A request enters as a token at cell
// zero and moves one cell per clock, so the length of the chain sets the
// timing. An accepted request is registered and passes the token register
// of every cell; its response is loaded into the output register as the
// input opens again, or waits in HOLD with the input closed while the output
// is stalled. The first matching cell serves the request. For an allocate
// that leaves bytes over while the last cell holds no entry, the same token
// drags an insert wave behind it that shifts later entries up one cell. One
// request is in flight at a time. A finished response waits in the output
// register while the next request is taken. No clearing pass after reset.
module first_fit_block_allocator_top import ffba_pkg::*; #(
  parameter int POOL_BYTES = POOL_BYTES_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int OW = $clog2(POOL_BYTES);
  localparam int SW = $clog2(POOL_BYTES + 1);

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    SCAN = 3'b010,
    HOLD = 3'b100
  } state_t;

  state_t        state;
  req_t          req_q;
  logic          launch;
  logic [SW-1:0] used;
  rsp_t          pend;
  rsp_t          fin;
  logic          out_free;
  logic          rsp_load;
  logic          last_val;

  tok_ctrl_t     ctrl  [MAX_BLOCKS+1];
  logic          cval  [MAX_BLOCKS+1];
  logic          calloc[MAX_BLOCKS+1];
  logic [OW-1:0] coff  [MAX_BLOCKS+1];
  logic [SW-1:0] csize [MAX_BLOCKS+1];
  logic [OW-1:0] roff  [MAX_BLOCKS+1];
  logic [SW-1:0] rsize [MAX_BLOCKS+1];
  logic          vals  [MAX_BLOCKS];
  logic [SW-1:0] used_next;

  // Inject the token at the head of the chain
  always_comb begin
    ctrl[0]        = '0;
    ctrl[0].active = launch;
    ctrl[0].func   = req_q.func;
    cval[0]        = 1'b0;
    calloc[0]      = 1'b0;
    coff[0]        = '0;
    csize[0]       = '0;
    roff[0]        = '0;
    rsize[0]       = '0;
  end

  assign last_val = vals[MAX_BLOCKS-1];

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ffba_cell #(
      .POOL_BYTES(POOL_BYTES),
      .FIRST     (k == 0),
      .OW        (OW),
      .SW        (SW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .full       (last_val),
      .req_size   (req_q.req_size),
      .free_offset(req_q.free_offset),
      .tin        (ctrl[k]),
      .tin_cval   (cval[k]),
      .tin_calloc (calloc[k]),
      .tin_coff   (coff[k]),
      .tin_csize  (csize[k]),
      .tin_roff   (roff[k]),
      .tin_rsize  (rsize[k]),
      .tout       (ctrl[k+1]),
      .tout_cval  (cval[k+1]),
      .tout_calloc(calloc[k+1]),
      .tout_coff  (coff[k+1]),
      .tout_csize (csize[k+1]),
      .tout_roff  (roff[k+1]),
      .tout_rsize (rsize[k+1]),
      .val        (vals[k])
    );
  end

  // Form the response when the token leaves the chain
  always_comb begin
    used_next = used;
    if (ctrl[MAX_BLOCKS].found) begin
      if (req_q.func == FUNC_ALLOC) begin
        used_next = used + SW'(req_q.req_size);
      end else begin
        used_next = used - rsize[MAX_BLOCKS];
      end
    end
    fin.ok            = ctrl[MAX_BLOCKS].found;
    fin.result_offset = (ctrl[MAX_BLOCKS].found && (req_q.func == FUNC_ALLOC)) ?
                        12'(roff[MAX_BLOCKS]) : 12'd0;
    fin.used_bytes    = 13'(used_next);
  end

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != IDLE);
  assign rsp_load  = ((state == SCAN) && ctrl[MAX_BLOCKS].active && out_free) ||
                     ((state == HOLD) && out_free);

  // Sequence requests through the chain and hold the response
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      launch    <= 1'b0;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      launch <= (state == IDLE) && req_valid;
      // Raise valid on a new response, drop it once taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= SCAN;
          end
        end
        SCAN: begin
          if (ctrl[MAX_BLOCKS].active) begin
            used <= used_next;
            if (out_free) begin
              rsp   <= fin;
              state <= IDLE;
            end else begin
              pend  <= fin;
              state <= HOLD;
            end
          end
        end
        HOLD: begin
          if (out_free) begin
            rsp   <= pend;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/ffba_checker.sv
// Port-level checks of the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_top_defines.svh.
`include "first_fit_block_allocator_top_defines.svh"

module ffba_checker import ffba_pkg::*; #(
  parameter int POOL_BYTES = POOL_BYTES_DEF
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  `FFBA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
  `FFBA_ASSERT_NEXT(a_no_rsp_early, req_valid && !req_stall && !rsp_valid, !rsp_valid)
  `FFBA_ASSERT_SAME(a_fail_offset, rsp_valid && !rsp.ok, rsp.result_offset == 12'd0)
  `FFBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind first_fit_block_allocator_top ffba_checker #(.POOL_BYTES(POOL_BYTES)) u_ffba_checker (.*);

>>> tb/sv/first_fit_block_allocator_top_tb.sv
// Testbench for the first-fit block allocator: directed and random requests
// checked against an in-bench table model. Depends on ffba_pkg and the top.
module first_fit_block_allocator_top_tb;
  import ffba_pkg::*;

  localparam int POOL = 4096;
  localparam int DEPTH = 64;
  localparam int LIMIT = 3000000;

  typedef struct {
    int unsigned off;
    int unsigned sz;
    bit taken;
  } blk_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  blk_t pool_table[DEPTH];
  int unsigned entry_total;
  int unsigned bytes_in_use;
  int live_offsets[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_rsp_cycles = 0;
  logic req_stall_seen = 1'b1;

  first_fit_block_allocator_top u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Compute the response of one request and update the table copy
  function automatic rsp_t allocate_or_free(req_t r);
    rsp_t o;
    int unsigned rest;
    o = '0;
    if (r.func == FUNC_ALLOC) begin
      if (r.req_size == 0) begin
        o.used_bytes = bytes_in_use[12:0];
        return o;
      end
      for (int i = 0; i < entry_total; i++) begin
        if (!pool_table[i].taken && pool_table[i].sz >= r.req_size) begin
          rest = pool_table[i].sz - r.req_size;
          pool_table[i].sz = r.req_size;
          pool_table[i].taken = 1;
          bytes_in_use += r.req_size;
          if (rest > 0 && entry_total < DEPTH) begin
            for (int j = entry_total; j > i + 1; j--) pool_table[j] = pool_table[j-1];
            pool_table[i+1].off = pool_table[i].off + r.req_size;
            pool_table[i+1].sz = rest;
            pool_table[i+1].taken = 0;
            entry_total++;
          end
          live_offsets.push_back(pool_table[i].off);
          o.ok = 1'b1;
          o.result_offset = pool_table[i].off[11:0];
          o.used_bytes = bytes_in_use[12:0];
          return o;
        end
      end
    end else begin
      for (int i = 0; i < entry_total; i++) begin
        if (pool_table[i].taken && pool_table[i].off == r.free_offset) begin
          pool_table[i].taken = 0;
          bytes_in_use -= pool_table[i].sz;
          o.ok = 1'b1;
          o.used_bytes = bytes_in_use[12:0];
          return o;
        end
      end
    end
    o.used_bytes = bytes_in_use[12:0];
    return o;
  endfunction

  task automatic push_req(logic f, int unsigned sz, int unsigned fo);
    req_t r;
    r.func = f;
    r.req_size = sz[12:0];
    r.free_offset = fo[11:0];
    pending_reqs.push_back(r);
  endtask

  // Pick a free offset: mostly a live block, sometimes noise
  function automatic int unsigned pick_free_offset();
    int k;
    if (live_offsets.size() > 0 && $urandom_range(99) < 80) begin
      k = $urandom_range(live_offsets.size() - 1);
      pick_free_offset = live_offsets[k];
      live_offsets.delete(k);
    end else begin
      pick_free_offset = $urandom_range(4095);
    end
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int n, int sidle, int rstall);
    int unsigned sz;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 55) begin
        case ($urandom_range(9))
          0: sz = $urandom_range(8191);
          1: sz = $urandom_range(4096, 3000);
          default: sz = $urandom_range(200, 1);
        endcase
        push_req(FUNC_ALLOC, sz, $urandom_range(4095));
      end else begin
        push_req(FUNC_FREE, $urandom_range(8191), pick_free_offset());
      end
    end
    wait_drained();
  endtask

  // Drive requests at the falling edge from the pending queue
  always @(negedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall_seen) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end else if (!req_valid) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end
      end
      if (hold_rsp_cycles > 0) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk) begin
    if (hold_rsp_cycles > 0) hold_rsp_cycles <= hold_rsp_cycles - 1;
  end

  // Note whether the request on the bus was taken, check responses
  always @(posedge clk) begin
    cycles <= cycles + 1;
    req_stall_seen <= !(req_valid && !req_stall) ? 1'b1 : 1'b0;
    if (!rst && req_valid && !req_stall) expected_rsps.push_back(allocate_or_free(req));
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", rsp);
      end else begin
        if (rsp !== expected_rsps[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp ok=%0d off=%0d used=%0d got ok=%0d off=%0d used=%0d",
                     expected_rsps[0].ok, expected_rsps[0].result_offset,
                     expected_rsps[0].used_bytes, rsp.ok, rsp.result_offset,
                     rsp.used_bytes);
        end
        void'(expected_rsps.pop_front());
      end
    end
    if (cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    entry_total = 1;
    bytes_in_use = 0;
    foreach (pool_table[i]) pool_table[i] = '{0, 0, 0};
    pool_table[0] = '{0, POOL, 0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed: zero size, oversize, whole pool, unknown and double free
    push_req(FUNC_ALLOC, 0, 4095);
    push_req(FUNC_ALLOC, 8191, 0);
    push_req(FUNC_ALLOC, 4097, 0);
    push_req(FUNC_ALLOC, 4096, 0);
    push_req(FUNC_ALLOC, 1, 0);
    push_req(FUNC_FREE, 0, 0);
    push_req(FUNC_FREE, 8191, 0);
    push_req(FUNC_FREE, 0, 4095);
    push_req(FUNC_ALLOC, 100, 0);
    push_req(FUNC_ALLOC, 200, 0);
    push_req(FUNC_FREE, 0, 100);
    push_req(FUNC_ALLOC, 50, 0);
    push_req(FUNC_ALLOC, 50, 0);
    push_req(FUNC_FREE, 0, 100);
    wait_drained();
    // Fill the table past its depth so the remainder gets lost
    for (int k = 0; k < 70; k++) push_req(FUNC_ALLOC, 1, 0);
    push_req(FUNC_ALLOC, 4096, 0);
    wait_drained();
    // Long receiver hold-off while the sender keeps offering
    hold_rsp_cycles = 600;
    random_phase(20, 0, 0);
    random_phase(400, 0, 0);
    random_phase(300, 82, 0);
    random_phase(300, 0, 82);
    random_phase(300, 7, 7);
    random_phase(250, 0, 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
